>>> hdl/spa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_pkg
// shared types, codes and class tables of the slab page allocator
// ----------------------------------------------------------------------------
package spa_pkg;

   localparam int CLASS_COUNT  = 7;
   localparam int HEADER_BYTES = 64;
   localparam int LARGEST_SLAB = 4032;
   localparam int PAGE_SHIFT   = 12;
   localparam logic [3:0] KIND_NONE = 4'd15;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_NO_PAGES    = 3'd1,
      ST_NOT_SLAB    = 3'd2,
      ST_IN_HEADER   = 3'd3,
      ST_MISALIGNED  = 3'd4,
      ST_NOT_ALLOC   = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_DECODE,
      S_READ,
      S_WAIT,
      S_ALLOC,
      S_FREE_DIV,
      S_FREE_CHK,
      S_WRITE,
      S_DONE
   } state_type;

   function automatic logic [11:0] class_size(input logic [2:0] c);
      case (c)
         3'd0: class_size = 12'd32;
         3'd1: class_size = 12'd64;
         3'd2: class_size = 12'd192;
         3'd3: class_size = 12'd448;
         3'd4: class_size = 12'd1008;
         3'd5: class_size = 12'd2016;
         default: class_size = 12'd4032;
      endcase
   endfunction

   function automatic logic [63:0] class_mask(input logic [2:0] c);
      case (c)
         3'd0: class_mask = 64'hffff_ffff_ffff_ffff;
         3'd1: class_mask = 64'h7fff_ffff_ffff_ffff;
         3'd2: class_mask = 64'h0000_0000_001f_ffff;
         3'd3: class_mask = 64'h0000_0000_0000_01ff;
         3'd4: class_mask = 64'h0000_0000_0000_000f;
         3'd5: class_mask = 64'h0000_0000_0000_0003;
         default: class_mask = 64'h0000_0000_0000_0001;
      endcase
   endfunction

endpackage

>>> hdl/spa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module spa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end

endmodule

>>> hdl/spa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_div
// shared divider by a slab block size, reciprocal multiply then back-multiply
// ----------------------------------------------------------------------------
module spa_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [11:0] dividend,
   input  logic [11:0] divisor,
   output logic        busy,
   output logic [11:0] quotient,
   output logic [11:0] remainder
);

   logic        busy_ff;
   logic [11:0] quo_ff;
   logic [11:0] rem_ff;
   logic [11:0] dvd_ff;
   logic [11:0] dsr_ff;
   logic [19:0] recip;
   logic [31:0] product;
   logic [23:0] back;

   // reciprocal of each block size scaled by 2^24, rounded up; exact below 4096
   always_comb begin
      case (divisor)
         12'd32:   recip = 20'd524288;
         12'd64:   recip = 20'd262144;
         12'd192:  recip = 20'd87382;
         12'd448:  recip = 20'd37450;
         12'd1008: recip = 20'd16645;
         12'd2016: recip = 20'd8323;
         default:  recip = 20'd4162;
      endcase
   end

   assign product = 32'(dividend) * 32'(recip);
   assign back    = 24'(quo_ff) * 24'(dsr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= start;
      end
   end

   // quotient registered on start, then remainder from the back-multiply of the registered quotient
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= 12'(product[31:24]);
         dvd_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= dvd_ff - back[11:0];
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> hdl/slab_page_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_page_allocator_unit
// slab and bump page allocator over a pool of fixed 4 KiB pages
// ----------------------------------------------------------------------------
// one request at a time; req_stall stays high while a request is in work.
// after reset a clearing pass writes every page's kind and bitmap entry, one
// page a cycle, so no request is taken until it ends. a slab allocate runs
// decode, page memory read, read wait, lowest-free-bit search, write back and
// done, skipping write back when it runs out of pages; a large allocate goes
// from decode to done; a query runs decode, read, read wait and done. a free
// runs decode, read, read wait, divide, check, write back and done when it
// clears a bit, skips write back on a failed offset check and goes from read
// wait to done for a non-slab page or an offset in the header. divide and
// check use the shared divider (reciprocal multiply, then back-multiply for
// the remainder) to split the page offset into block index and remainder.
// idle comes between requests. the response sits in an output register until
// the far side takes it; the engine only waits in done while it is still full.
// ----------------------------------------------------------------------------
module slab_page_allocator_unit #(
   parameter int POOL_PAGES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [23:0] req_request_size,
   input  logic [22:0] req_address,
   input  logic        req_null_pointer,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [22:0] rsp_result_address,
   output logic [11:0] rsp_usable_size,
   output logic [2:0]  rsp_status
);

   localparam int PW = $clog2(POOL_PAGES);   // page index width
   localparam int NW = PW + 1;               // bump pointer width
   localparam int EW = ((NW > 13) ? NW : 13) + 1;   // bump end width for large requests

   spa_pkg::state_type state_ff, state_in;

   // captured request
   logic [1:0]  cmd_ff;
   logic [23:0] size_ff;
   logic [22:0] addr_ff;
   logic        null_ff;

   // allocator state outside the page memories
   logic [PW-1:0] head_ff [spa_pkg::CLASS_COUNT];
   logic [NW-1:0] next_ff;
   logic [NW-1:0] clr_ff;

   // working registers
   logic [2:0]    class_ff;
   logic [PW-1:0] page_ff;
   logic [6:0]    bit_ff;
   logic          newpage_ff;

   // page memories
   logic          mem_we;
   logic [PW-1:0] mem_addr;
   logic [3:0]    kind_wd, kind_rd;
   logic [63:0]   bmp_wd, bmp_rd;

   // response being built
   logic        out_valid_ff;
   logic [22:0] out_addr_ff;
   logic [11:0] out_size_ff;
   logic [2:0]  out_status_ff;

   // output register
   logic [22:0] hold_addr_ff;
   logic [11:0] hold_size_ff;
   logic [2:0]  hold_status_ff;

   // divider
   logic        div_start, div_busy;
   logic [11:0] div_q, div_r;

   spa_ram #(.WIDTH(4), .DEPTH(POOL_PAGES)) u_kind (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr),
      .wr_data(kind_wd), .rd_data(kind_rd));

   spa_ram #(.WIDTH(64), .DEPTH(POOL_PAGES)) u_bitmap (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr),
      .wr_data(bmp_wd), .rd_data(bmp_rd));

   spa_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(addr_ff[11:0] - 12'(spa_pkg::HEADER_BYTES)),
      .divisor(spa_pkg::class_size(kind_rd[2:0])),
      .busy(div_busy), .quotient(div_q), .remainder(div_r));

   // request decode helpers
   logic [2:0]  size_class;
   logic [12:0] large_count;
   logic [EW-1:0] large_end;
   logic        page_oob;
   logic [63:0] open_slots;
   logic [6:0]  low_bit;

   always_comb begin
      // smallest class that fits, size zero lands in class 0
      size_class = 3'd6;
      for (int c = 5; c >= 0; c--) begin
         if (size_ff[11:0] <= spa_pkg::class_size(3'(c)) && size_ff[23:12] == '0) begin
            size_class = 3'(c);
         end
      end
   end

   assign large_count = size_ff[23:12] + 13'(size_ff[11:0] != '0);
   assign large_end   = EW'(next_ff) + EW'(large_count);
   assign page_oob    = (addr_ff[22:12] >> PW) != '0;

   // lowest free block of the head page
   assign open_slots = ~bmp_rd & spa_pkg::class_mask(class_ff);
   always_comb begin
      low_bit = 7'd64;
      for (int i = 63; i >= 0; i--) begin
         if (open_slots[i]) low_bit = 7'(i);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spa_pkg::S_CLEAR:  if (clr_ff == NW'(POOL_PAGES - 1)) state_in = spa_pkg::S_IDLE;
         spa_pkg::S_IDLE:   if (req_valid) state_in = spa_pkg::S_DECODE;
         spa_pkg::S_DECODE: begin
            unique case (spa_pkg::cmd_type'(cmd_ff))
               spa_pkg::CMD_ALLOC:
                  if (size_ff > 24'(spa_pkg::LARGEST_SLAB)) state_in = spa_pkg::S_DONE;
                  else state_in = spa_pkg::S_READ;
               spa_pkg::CMD_FREE, spa_pkg::CMD_QUERY:
                  if (null_ff || page_oob) state_in = spa_pkg::S_DONE;
                  else state_in = spa_pkg::S_READ;
               default: state_in = spa_pkg::S_DONE;
            endcase
         end
         spa_pkg::S_READ:   state_in = spa_pkg::S_WAIT;
         spa_pkg::S_WAIT: begin
            if (spa_pkg::cmd_type'(cmd_ff) == spa_pkg::CMD_ALLOC) state_in = spa_pkg::S_ALLOC;
            else if (spa_pkg::cmd_type'(cmd_ff) == spa_pkg::CMD_FREE &&
                     kind_rd < 4'(spa_pkg::CLASS_COUNT) &&
                     addr_ff[11:0] >= 12'(spa_pkg::HEADER_BYTES))
               state_in = spa_pkg::S_FREE_DIV;
            else state_in = spa_pkg::S_DONE;
         end
         spa_pkg::S_ALLOC: begin
            if (low_bit == 7'd64 && next_ff >= NW'(POOL_PAGES)) state_in = spa_pkg::S_DONE;
            else state_in = spa_pkg::S_WRITE;
         end
         spa_pkg::S_FREE_DIV: state_in = spa_pkg::S_FREE_CHK;
         spa_pkg::S_FREE_CHK: begin
            if (!div_busy) begin
               if (div_r == '0 && div_q <= 12'd63 && bmp_rd[div_q[5:0]])
                  state_in = spa_pkg::S_WRITE;
               else state_in = spa_pkg::S_DONE;
            end
         end
         spa_pkg::S_WRITE:  state_in = spa_pkg::S_DONE;
         spa_pkg::S_DONE:   if (!out_valid_ff || !rsp_stall) state_in = spa_pkg::S_IDLE;
         default:           state_in = spa_pkg::S_IDLE;
      endcase
   end

   // memory port and divider controls
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = page_ff;
      kind_wd   = kind_rd;
      bmp_wd    = bmp_rd;
      div_start = 1'b0;
      unique case (state_ff)
         spa_pkg::S_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff[PW-1:0];
            kind_wd  = (clr_ff < NW'(spa_pkg::CLASS_COUNT)) ? 4'(clr_ff) : spa_pkg::KIND_NONE;
            bmp_wd   = '0;
         end
         spa_pkg::S_FREE_DIV: div_start = 1'b1;
         spa_pkg::S_WRITE: begin
            mem_we = 1'b1;
            if (spa_pkg::cmd_type'(cmd_ff) == spa_pkg::CMD_ALLOC) begin
               kind_wd = newpage_ff ? 4'(class_ff) : kind_rd;
               bmp_wd  = (newpage_ff ? 64'd0 : bmp_rd) | (64'd1 << bit_ff[5:0]);
            end else begin
               bmp_wd = bmp_rd & ~(64'd1 << bit_ff[5:0]);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spa_pkg::S_CLEAR;
         clr_ff       <= '0;
         next_ff      <= NW'(spa_pkg::CLASS_COUNT);
         out_valid_ff <= 1'b0;
         for (int c = 0; c < spa_pkg::CLASS_COUNT; c++) head_ff[c] <= PW'(c);
      end else begin
         state_ff <= state_in;
         if (state_ff == spa_pkg::S_CLEAR) clr_ff <= clr_ff + NW'(1);
         if (state_ff == spa_pkg::S_DONE && state_in == spa_pkg::S_IDLE) out_valid_ff <= 1'b1;
         else if (out_valid_ff && !rsp_stall) out_valid_ff <= 1'b0;
         // bump allocation of large requests
         if (state_ff == spa_pkg::S_DECODE && spa_pkg::cmd_type'(cmd_ff) == spa_pkg::CMD_ALLOC &&
             size_ff > 24'(spa_pkg::LARGEST_SLAB) && large_end <= EW'(POOL_PAGES))
            next_ff <= large_end[NW-1:0];
         // class head page full: promote a fresh bump page
         if (state_ff == spa_pkg::S_ALLOC && low_bit == 7'd64 && next_ff < NW'(POOL_PAGES)) begin
            next_ff           <= next_ff + NW'(1);
            head_ff[class_ff] <= next_ff[PW-1:0];
         end
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (state_ff == spa_pkg::S_IDLE && req_valid) begin
         cmd_ff  <= req_command;
         size_ff <= req_request_size;
         addr_ff <= req_address;
         null_ff <= req_null_pointer;
      end
      // response moves to the output register as done hands over
      if (state_ff == spa_pkg::S_DONE && state_in == spa_pkg::S_IDLE) begin
         hold_addr_ff   <= out_addr_ff;
         hold_size_ff   <= out_size_ff;
         hold_status_ff <= out_status_ff;
      end
      unique case (state_ff)
         spa_pkg::S_DECODE: begin
            class_ff    <= size_class;
            page_ff     <= (spa_pkg::cmd_type'(cmd_ff) == spa_pkg::CMD_ALLOC) ?
                           head_ff[size_class] : PW'(addr_ff[22:12]);
            out_size_ff <= '0;
            if (spa_pkg::cmd_type'(cmd_ff) == spa_pkg::CMD_ALLOC &&
                size_ff > 24'(spa_pkg::LARGEST_SLAB)) begin
               if (large_end > EW'(POOL_PAGES)) begin
                  out_addr_ff   <= '0;
                  out_status_ff <= spa_pkg::ST_NO_PAGES;
               end else begin
                  out_addr_ff   <= 23'({next_ff, 12'd0});
                  out_status_ff <= spa_pkg::ST_OK;
               end
            end else begin
               out_addr_ff <= '0;
               if ((spa_pkg::cmd_type'(cmd_ff) == spa_pkg::CMD_QUERY && (null_ff || page_oob)) ||
                   (spa_pkg::cmd_type'(cmd_ff) == spa_pkg::CMD_FREE && !null_ff && page_oob))
                  out_status_ff <= spa_pkg::ST_NOT_SLAB;
               else out_status_ff <= spa_pkg::ST_OK;
            end
         end
         spa_pkg::S_WAIT: begin
            if (spa_pkg::cmd_type'(cmd_ff) != spa_pkg::CMD_ALLOC) begin
               if (kind_rd >= 4'(spa_pkg::CLASS_COUNT)) out_status_ff <= spa_pkg::ST_NOT_SLAB;
               else if (spa_pkg::cmd_type'(cmd_ff) == spa_pkg::CMD_QUERY)
                  out_size_ff <= spa_pkg::class_size(kind_rd[2:0]);
               else if (addr_ff[11:0] < 12'(spa_pkg::HEADER_BYTES))
                  out_status_ff <= spa_pkg::ST_IN_HEADER;
            end
         end
         spa_pkg::S_ALLOC: begin
            newpage_ff <= (low_bit == 7'd64);
            if (low_bit == 7'd64) begin
               if (next_ff >= NW'(POOL_PAGES)) out_status_ff <= spa_pkg::ST_NO_PAGES;
               else begin
                  page_ff     <= next_ff[PW-1:0];
                  bit_ff      <= '0;
                  out_addr_ff <= 23'({next_ff, 12'd0}) + 23'(spa_pkg::HEADER_BYTES);
               end
            end else begin
               bit_ff      <= low_bit;
               // block offset by multiplying the block index by the class size
               out_addr_ff <= 23'({page_ff, 12'd0}) + 23'(spa_pkg::HEADER_BYTES) +
                              23'(low_bit) * 23'(spa_pkg::class_size(class_ff));
            end
         end
         spa_pkg::S_FREE_CHK: begin
            if (!div_busy) begin
               bit_ff <= div_q[6:0];
               if (div_r != '0) out_status_ff <= spa_pkg::ST_MISALIGNED;
               else if (div_q > 12'd63 || !bmp_rd[div_q[5:0]])
                  out_status_ff <= spa_pkg::ST_NOT_ALLOC;
            end
         end
         default: ;
      endcase
   end

   assign req_stall          = (state_ff != spa_pkg::S_IDLE);
   assign rsp_valid          = out_valid_ff;
   assign rsp_result_address = hold_addr_ff;
   assign rsp_usable_size    = hold_size_ff;
   assign rsp_status         = hold_status_ff;

   // no request taken during the clearing pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == spa_pkg::S_CLEAR |-> req_stall)
      else $error("request taken while clearing");

   // bump pointer never runs past the pool
   a_next_bound: assert property (@(posedge clock) disable iff (reset)
      next_ff <= NW'(POOL_PAGES))
      else $error("bump pointer beyond pool");

   // a failed request never reports an address
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != 3'(spa_pkg::ST_OK) |-> rsp_result_address == '0)
      else $error("address on failed request");

endmodule

>>> dv/slab_page_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_page_allocator_unit_tb
// self-checking bench for the slab and bump page allocator
// ----------------------------------------------------------------------------
// a shadow of the page pool (kinds, bitmaps, class heads, bump pointer) is
// updated on every accepted request and predicts the response, which is
// checked field by field in order. directed requests cover every class edge,
// large and oversized allocations and each free/query error; random traffic
// then mixes well-formed frees of live blocks with broken addresses until
// the pool runs dry. sender bursts and receiver stalls vary throughout.
// ----------------------------------------------------------------------------
module slab_page_allocator_unit_tb;

   localparam int POOL = 2048;
   localparam int PAGE = 4096;

   typedef struct packed {
      spa_pkg::cmd_type command;
      logic [23:0]      size;
      logic [22:0]      address;
      logic             is_null;
   } request_type;

   typedef struct packed {
      logic [22:0]         address;
      logic [11:0]         usable;
      spa_pkg::status_type status;
   } outcome_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_command;
   logic [23:0] req_request_size;
   logic [22:0] req_address;
   logic        req_null_pointer;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [22:0] rsp_result_address;
   logic [11:0] rsp_usable_size;
   logic [2:0]  rsp_status;

   slab_page_allocator_unit #(.POOL_PAGES(POOL)) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_request_size   (req_request_size),
      .req_address        (req_address),
      .req_null_pointer   (req_null_pointer),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_address (rsp_result_address),
      .rsp_usable_size    (rsp_usable_size),
      .rsp_status         (rsp_status)
   );

   // shadow pool state
   logic [3:0]  shadow_kind [POOL];
   logic [63:0] shadow_bitmap [POOL];
   int          shadow_head [spa_pkg::CLASS_COUNT];
   int          shadow_bump;
   int          block_bytes [spa_pkg::CLASS_COUNT] = '{32, 64, 192, 448, 1008, 2016, 4032};
   int          blocks_per_page [spa_pkg::CLASS_COUNT] = '{64, 63, 21, 9, 4, 2, 1};

   request_type pending_requests [$];
   outcome_type awaited_responses [$];
   int          live_blocks [$];
   int          issued_count;
   int          taken_count;
   int          error_count;
   int          status_seen [8];
   int          burst_left;
   int          gap_left;
   int          stall_mode;
   int          stall_phase;

   // clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   task automatic report(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic void pool_reset();
      for (int p = 0; p < POOL; p++) begin
         shadow_kind[p] = spa_pkg::KIND_NONE;
         shadow_bitmap[p] = '0;
      end
      for (int c = 0; c < spa_pkg::CLASS_COUNT; c++) begin
         shadow_kind[c] = 4'(c);
         shadow_head[c] = c;
      end
      shadow_bump = spa_pkg::CLASS_COUNT;
   endfunction

   // allocate path: slab class lookup or bump pages
   function automatic outcome_type pool_allocate(input int size);
      outcome_type o;
      int          c;
      int          page;
      int          bit_index;
      int          count;
      logic [63:0] usable_mask;
      o = '{address: '0, usable: '0, status: spa_pkg::ST_OK};
      if (size > spa_pkg::LARGEST_SLAB) begin
         count = (size + PAGE - 1) / PAGE;
         if (shadow_bump + count > POOL) begin
            o.status = spa_pkg::ST_NO_PAGES;
            return o;
         end
         o.address = 23'(shadow_bump * PAGE);
         shadow_bump += count;
         return o;
      end
      c = 0;
      while (c < spa_pkg::CLASS_COUNT - 1 && size > block_bytes[c]) c++;
      usable_mask = (blocks_per_page[c] >= 64) ? '1 : ((64'd1 << blocks_per_page[c]) - 1);
      page = shadow_head[c];
      bit_index = -1;
      for (int b = 63; b >= 0; b--)
         if (!shadow_bitmap[page][b] && usable_mask[b]) bit_index = b;
      if (bit_index < 0) begin
         if (shadow_bump + 1 > POOL) begin
            o.status = spa_pkg::ST_NO_PAGES;
            return o;
         end
         page = shadow_bump;
         shadow_bump++;
         shadow_kind[page] = 4'(c);
         shadow_bitmap[page] = '0;
         shadow_head[c] = page;
         bit_index = 0;
      end
      shadow_bitmap[page][bit_index] = 1'b1;
      o.address = 23'(page * PAGE + spa_pkg::HEADER_BYTES + bit_index * block_bytes[c]);
      live_blocks.push_back(int'(o.address));
      return o;
   endfunction

   function automatic spa_pkg::status_type pool_free(input int address);
      int page;
      int offset;
      int c;
      int rel;
      int idx;
      page = address / PAGE;
      offset = address % PAGE;
      if (page >= POOL || shadow_kind[page] >= spa_pkg::CLASS_COUNT) return spa_pkg::ST_NOT_SLAB;
      c = shadow_kind[page];
      if (offset < spa_pkg::HEADER_BYTES) return spa_pkg::ST_IN_HEADER;
      rel = offset - spa_pkg::HEADER_BYTES;
      if (rel % block_bytes[c] != 0) return spa_pkg::ST_MISALIGNED;
      idx = rel / block_bytes[c];
      if (idx > 63 || !shadow_bitmap[page][idx]) return spa_pkg::ST_NOT_ALLOC;
      shadow_bitmap[page][idx] = 1'b0;
      foreach (live_blocks[i])
         if (live_blocks[i] == address) begin
            live_blocks.delete(i);
            break;
         end
      return spa_pkg::ST_OK;
   endfunction

   function automatic outcome_type pool_predict(input request_type r);
      outcome_type o;
      int          page;
      o = '{address: '0, usable: '0, status: spa_pkg::ST_OK};
      case (r.command)
         spa_pkg::CMD_ALLOC: o = pool_allocate(int'(r.size));
         spa_pkg::CMD_FREE: if (!r.is_null) o.status = pool_free(int'(r.address));
         spa_pkg::CMD_QUERY: begin
            page = int'(r.address) / PAGE;
            if (r.is_null || page >= POOL || shadow_kind[page] >= spa_pkg::CLASS_COUNT)
               o.status = spa_pkg::ST_NOT_SLAB;
            else
               o.usable = 12'(block_bytes[shadow_kind[page]]);
         end
         default: ;
      endcase
      return o;
   endfunction

   // driver: bursts of requests with random gaps, inputs move on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && taken_count != issued_count)) begin
         if (burst_left == 0 && gap_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            request_type r;
            r = pending_requests.pop_front();
            req_valid        <= 1'b1;
            req_command      <= r.command;
            req_request_size <= r.size;
            req_address      <= r.address;
            req_null_pointer <= r.is_null;
            issued_count++;
            burst_left--;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern: long stretches of none, light or heavy back-pressure
   always @(negedge clock) begin
      if (stall_phase == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_phase = $urandom_range(50, 400);
      end
      stall_phase--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) < 3);
         default: rsp_stall <= ($urandom_range(0, 9) < 8);
      endcase
   end

   // monitor: predict on request accept, check on response accept
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         request_type r;
         r = '{command: spa_pkg::cmd_type'(req_command), size: req_request_size,
               address: req_address, is_null: req_null_pointer};
         awaited_responses.push_back(pool_predict(r));
         taken_count++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_responses.size() == 0) begin
            report("response with nothing outstanding");
         end else begin
            outcome_type e;
            e = awaited_responses.pop_front();
            status_seen[rsp_status]++;
            if (rsp_result_address !== e.address)
               report($sformatf("address %0h, predicted %0h", rsp_result_address, e.address));
            if (rsp_usable_size !== e.usable)
               report($sformatf("usable size %0d, predicted %0d", rsp_usable_size, e.usable));
            if (rsp_status !== e.status)
               report($sformatf("status %0d, predicted %0d", rsp_status, e.status));
         end
      end
   end

   task automatic queue_request(input spa_pkg::cmd_type c, input int size, input int address,
                                input logic is_null);
      wait (pending_requests.size() < 4);
      pending_requests.push_back('{command: c, size: 24'(size), address: 23'(address),
                                   is_null: is_null});
   endtask

   function automatic int some_address();
      int page;
      if (live_blocks.size() > 0 && $urandom_range(0, 1))
         return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
      case ($urandom_range(0, 3))
         0: return int'($urandom) & 32'h7fffff;
         1: begin
            page = $urandom_range(0, shadow_bump + 2);
            return page * PAGE + int'($urandom_range(0, PAGE - 1));
         end
         default: begin
            page = $urandom_range(0, (shadow_bump > 1) ? shadow_bump - 1 : 0);
            return page * PAGE + spa_pkg::HEADER_BYTES + 32 * int'($urandom_range(0, 125));
         end
      endcase
   endfunction

   // stimulus
   initial begin
      int pick;
      int size;
      int addr;
      int live;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = spa_pkg::CMD_ALLOC;
      req_request_size = '0;
      req_address = '0;
      req_null_pointer = 1'b0;
      rsp_stall = 1'b0;
      issued_count = 0;
      taken_count = 0;
      error_count = 0;
      burst_left = 0;
      gap_left = 0;
      stall_phase = 0;
      pool_reset();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: class edges, large and oversized requests, every free and query error
      foreach (block_bytes[c]) begin
         queue_request(spa_pkg::CMD_ALLOC, block_bytes[c], 0, 1'b0);
         if (c < spa_pkg::CLASS_COUNT - 1)
            queue_request(spa_pkg::CMD_ALLOC, block_bytes[c] + 1, 0, 1'b0);
      end
      queue_request(spa_pkg::CMD_ALLOC, 0, 23'h7fffff, 1'b1);          // size zero
      queue_request(spa_pkg::CMD_ALLOC, 4096, 0, 1'b0);                // one bump page
      queue_request(spa_pkg::CMD_ALLOC, 24'hffffff, 0, 1'b0);          // out of pages
      queue_request(spa_pkg::CMD_ALLOC, 8388608, 0, 1'b0);
      queue_request(spa_pkg::CMD_FREE, 0, 64, 1'b0);                   // live class 0 block
      queue_request(spa_pkg::CMD_FREE, 0, 64, 1'b0);                   // second free
      queue_request(spa_pkg::CMD_FREE, 0, 32, 1'b0);                   // in header
      queue_request(spa_pkg::CMD_FREE, 0, PAGE + 65, 1'b0);            // misaligned
      queue_request(spa_pkg::CMD_FREE, 0, 64 + 64 * 32, 1'b0);         // past the bitmap
      queue_request(spa_pkg::CMD_FREE, 0, 7 * PAGE, 1'b0);             // class 6 page header
      queue_request(spa_pkg::CMD_FREE, 24'hffffff, 23'h7fffff, 1'b1);  // null
      queue_request(spa_pkg::CMD_QUERY, 0, 3 * PAGE + 100, 1'b0);
      queue_request(spa_pkg::CMD_QUERY, 0, 2 * PAGE, 1'b1);            // null query
      queue_request(spa_pkg::CMD_QUERY, 0, 23'h7fffff, 1'b0);          // unused top page
      queue_request(spa_pkg::CMD_NONE, 24'hffffff, 23'h7fffff, 1'b1);

      // random traffic until the pool is exhausted and beyond
      for (int n = 0; n < 1950; n++) begin
         if (n == 900) begin
            // drain fully once before carrying on
            wait (pending_requests.size() == 0 && issued_count == taken_count
                  && awaited_responses.size() == 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            size = $urandom_range(0, 1) ? $urandom_range(0, 70) : $urandom_range(0, 4032);
            queue_request(spa_pkg::CMD_ALLOC, size, $urandom, 1'($urandom_range(0, 1)));
         end else if (pick < 45) begin
            case ($urandom_range(0, 19))
               0: size = int'($urandom) & 32'hffffff;
               1, 2, 3: size = $urandom_range(4033, 400000);
               default: size = $urandom_range(4033, 65536);
            endcase
            queue_request(spa_pkg::CMD_ALLOC, size, $urandom, 1'($urandom_range(0, 1)));
         end else if (pick < 75 && live_blocks.size() > 0) begin
            live = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            queue_request(spa_pkg::CMD_FREE, $urandom, live, 1'b0);
         end else if (pick < 85) begin
            addr = some_address();
            queue_request(spa_pkg::CMD_FREE, $urandom, addr, $urandom_range(0, 9) == 0);
         end else if (pick < 97) begin
            addr = some_address();
            queue_request(spa_pkg::CMD_QUERY, $urandom, addr, $urandom_range(0, 9) == 0);
         end else begin
            queue_request(spa_pkg::CMD_NONE, $urandom, $urandom, 1'($urandom_range(0, 1)));
         end
      end

      wait (pending_requests.size() == 0 && issued_count == taken_count
            && awaited_responses.size() == 0);
      repeat (40) @(posedge clock);
      $display("covered %0d requests, %0d pages bumped, %0d blocks still live", taken_count,
               shadow_bump, live_blocks.size());
      $display("statuses: ok %0d, no pages %0d, not slab %0d, header %0d, misaligned %0d, free %0d",
               status_seen[spa_pkg::ST_OK], status_seen[spa_pkg::ST_NO_PAGES],
               status_seen[spa_pkg::ST_NOT_SLAB], status_seen[spa_pkg::ST_IN_HEADER],
               status_seen[spa_pkg::ST_MISALIGNED], status_seen[spa_pkg::ST_NOT_ALLOC]);
      if (error_count == 0 && awaited_responses.size() == 0) begin
         $display("slab_page_allocator_unit_tb: PASS");
      end else begin
         $display("slab_page_allocator_unit_tb: FAIL");
      end
      $finish;
   end

   // run limit
   initial begin
      #30ms;
      $display("timeout with %0d responses outstanding", awaited_responses.size());
      $display("slab_page_allocator_unit_tb: FAIL");
      $finish;
   end

endmodule
